FILE: hdl/assert_macros.svh
// Assertion helpers included by the top-level file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside of reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/esp_pkg.sv
package esp_pkg;

    // Setpoint width and the limits that follow from it.
    localparam int SP_BITS = 16;
    localparam logic [SP_BITS-1:0] SP_MAX = {SP_BITS{1'b1}};

    localparam int STEP_W = 15;
    localparam int THR_W  = 9;
    localparam int CNT_W  = 8;
    localparam int OUT_W  = 16;
    localparam int DAC_W  = 12;

    // The sum of a setpoint and a step never overflows this width.
    localparam int SUM_W = ((SP_BITS > STEP_W) ? SP_BITS : STEP_W) + 1;

    // Shifts that take the top twelve bits of a setpoint.
    localparam int TOP_SHR = (SP_BITS >= DAC_W) ? SP_BITS - DAC_W : 0;
    localparam int TOP_SHL = (SP_BITS < DAC_W) ? DAC_W - SP_BITS : 0;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // DAC command nibbles for the two channels.
    localparam logic [3:0] DAC_V_CMD = 4'h3;
    localparam logic [3:0] DAC_I_CMD = 4'hB;

    // APB port geometry.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_SLOW_V = 3'd0,
        REG_FAST_V = 3'd1,
        REG_SLOW_I = 3'd2,
        REG_FAST_I = 3'd3,
        REG_THRESH = 3'd4
    } t_reg_idx;

    localparam logic [STEP_W-1:0] RST_SLOW_V = 15'd16;
    localparam logic [STEP_W-1:0] RST_FAST_V = 15'd256;
    localparam logic [STEP_W-1:0] RST_SLOW_I = 15'd64;
    localparam logic [STEP_W-1:0] RST_FAST_I = 15'd256;
    localparam logic [THR_W-1:0]  RST_THRESH = 9'd5;

    // Switch codes.
    typedef enum logic [1:0] {
        SW_NONE    = 2'd0,
        SW_OUTPUT  = 2'd1,
        SW_ENCODER = 2'd2,
        SW_BOTH    = 2'd3
    } t_switch;

    // Detent codes.
    typedef enum logic [1:0] {
        DET_NONE = 2'd0,
        DET_CW   = 2'd1,
        DET_CCW  = 2'd2
    } t_detent;

    // Level history, entry 0 is the newest level.
    typedef logic [3:0][1:0] t_hist;

    localparam t_hist HIST_IDLE = 8'b11_11_11_11;
    localparam t_hist HIST_CW   = 8'b10_00_01_11;
    localparam t_hist HIST_CCW  = 8'b01_00_10_11;

    typedef struct packed {
        logic [STEP_W-1:0] slow_v;
        logic [STEP_W-1:0] fast_v;
        logic [STEP_W-1:0] slow_i;
        logic [STEP_W-1:0] fast_i;
        logic [THR_W-1:0]  thresh;
    } t_cfg;

    typedef struct packed {
        logic [1:0] level;
        t_switch    sw;
        logic       tick;
    } t_item;

    typedef struct packed {
        logic [OUT_W-1:0] voltage;
        logic [OUT_W-1:0] current;
        logic             output_on;
        logic             adj_current;
        logic             fast_mode;
        t_detent          detent;
        logic [15:0]      dac_v;
        logic [15:0]      dac_i;
        logic             dac_update;
        logic             beep;
    } t_result;

    // Top twelve bits of a setpoint, zero filled below when it is narrower.
    function automatic logic [DAC_W-1:0] top12(input logic [SP_BITS-1:0] v);
        logic [DAC_W+SP_BITS-1:0] wide;
        wide = {{DAC_W{1'b0}}, v};
        wide = (wide >> TOP_SHR) << TOP_SHL;
        return wide[DAC_W-1:0];
    endfunction

    // Low sixteen bits of a setpoint, zero extended when it is narrower.
    function automatic logic [OUT_W-1:0] to_out(input logic [SP_BITS-1:0] v);
        logic [OUT_W+SP_BITS-1:0] wide;
        wide = {{OUT_W{1'b0}}, v};
        return wide[OUT_W-1:0];
    endfunction

endpackage

FILE: hdl/encoder_setpoint_panel_top.sv
// Channel   Handshake                 Payload
// poll      i_in_valid / o_in_ready   i_encoder_level, i_switch_code, i_tick
// result    o_out_valid / i_out_ready o_voltage_setpoint ... o_beep
// config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A poll is taken into the input register, updated in one pass of logic and
// moves into the result register once that register is free or being emptied;
// the result is then valid at the output.
// One poll is accepted every cycle; the result register is the only limit.
// Synchronous active-low reset restores flags, core state and register defaults.
// While a result waits, a new poll still fills the empty input register.
`include "assert_macros.svh"

module encoder_setpoint_panel_top
    import esp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_encoder_level,
    input  logic [1:0]        i_switch_code,
    input  logic              i_tick,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_voltage_setpoint,
    output logic [15:0]       o_current_setpoint,
    output logic              o_output_on,
    output logic              o_adjusting_current,
    output logic              o_fast_mode,
    output logic [1:0]        o_detent,
    output logic [15:0]       o_dac_voltage_word,
    output logic [15:0]       o_dac_current_word,
    output logic              o_dac_update,
    output logic              o_beep,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    t_cfg    cfg;
    t_result result;

    // Move an item on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    esp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    esp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.level <= i_encoder_level;
            r_in.sw    <= t_switch'(i_switch_code);
            r_in.tick  <= i_tick;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_voltage_setpoint  = r_out.voltage;
    assign o_current_setpoint  = r_out.current;
    assign o_output_on         = r_out.output_on;
    assign o_adjusting_current = r_out.adj_current;
    assign o_fast_mode         = r_out.fast_mode;
    assign o_detent            = r_out.detent;
    assign o_dac_voltage_word  = r_out.dac_v;
    assign o_dac_current_word  = r_out.dac_i;
    assign o_dac_update        = r_out.dac_update;
    assign o_beep              = r_out.beep;

    // An empty input register always takes a new request.
    `ASSERT_IMPL(a_in_free, i_clk, i_rst_n, !r_in_valid, o_in_ready, "empty input stage stalled")
    // The DAC update flag follows the detent code.
    `ASSERT_IMPL(a_dac_upd, i_clk, i_rst_n, o_out_valid, o_dac_update == (o_detent != DET_NONE),
        "dac update and detent disagree")
    // The detent code never takes the unused value.
    `ASSERT_IMPL(a_det_code, i_clk, i_rst_n, o_out_valid, o_detent <= DET_CCW,
        "illegal detent code")
    // A fresh result follows every item that moves on.
    `ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, advance, o_out_valid, "result lost")

endmodule

FILE: hdl/esp_cfg.sv
module esp_cfg
    import esp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_v <= RST_SLOW_V;
            r_cfg.fast_v <= RST_FAST_V;
            r_cfg.slow_i <= RST_SLOW_I;
            r_cfg.fast_i <= RST_FAST_I;
            r_cfg.thresh <= RST_THRESH;
        end else if (wr_en) begin
            unique case (idx)
                REG_SLOW_V: r_cfg.slow_v <= pwdata[STEP_W-1:0];
                REG_FAST_V: r_cfg.fast_v <= pwdata[STEP_W-1:0];
                REG_SLOW_I: r_cfg.slow_i <= pwdata[STEP_W-1:0];
                REG_FAST_I: r_cfg.fast_i <= pwdata[STEP_W-1:0];
                REG_THRESH: r_cfg.thresh <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer; addresses past the list read as zero.
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_SLOW_V: prdata = APB_DW'(r_cfg.slow_v);
            REG_FAST_V: prdata = APB_DW'(r_cfg.fast_v);
            REG_SLOW_I: prdata = APB_DW'(r_cfg.slow_i);
            REG_FAST_I: prdata = APB_DW'(r_cfg.fast_i);
            REG_THRESH: prdata = APB_DW'(r_cfg.thresh);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: hdl/esp_core.sv
module esp_core
    import esp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_hist              r_hist,    n_hist;
    logic [CNT_W-1:0]   r_rot,     n_rot;
    logic [CNT_W-1:0]   r_prev,    n_prev;
    logic               r_fast,    n_fast;
    logic               r_sel,     n_sel;
    logic               r_out_on,  n_out_on;
    logic [SP_BITS-1:0] r_volt,    n_volt;
    logic [SP_BITS-1:0] r_curr,    n_curr;

    t_hist              shifted;
    t_detent            det;
    logic [STEP_W-1:0]  step;
    logic [SP_BITS-1:0] moved;
    logic               beep;
    logic [THR_W-1:0]   rate_sum;

    // Saturating move of a setpoint by one step.
    function automatic logic [SP_BITS-1:0] sat_move(
        input logic [SP_BITS-1:0] v,
        input logic [STEP_W-1:0]  s,
        input logic               up
    );
        logic [SUM_W-1:0] wv;
        logic [SUM_W-1:0] ws;
        logic [SUM_W-1:0] res;
        wv = SUM_W'(v);
        ws = SUM_W'(s);
        if (up) begin
            res = wv + ws;
            if (res >= SUM_W'(SP_MAX)) begin
                res = SUM_W'(SP_MAX);
            end
        end else begin
            res = (wv <= ws) ? '0 : wv - ws;
        end
        return res[SP_BITS-1:0];
    endfunction

    // Next state for the item leaving the input register.
    always_comb begin
        n_hist   = r_hist;
        n_rot    = r_rot;
        n_prev   = r_prev;
        n_fast   = r_fast;
        n_sel    = r_sel;
        n_out_on = r_out_on;
        n_volt   = r_volt;
        n_curr   = r_curr;
        beep     = 1'b0;
        det      = DET_NONE;

        // A changed level enters the history.
        shifted = (i_item.level != r_hist[0]) ? t_hist'({r_hist[2:0], i_item.level})
                                              : r_hist;
        n_hist  = shifted;
        if (shifted == HIST_CW) begin
            det = DET_CW;
        end else if (shifted == HIST_CCW) begin
            det = DET_CCW;
        end

        // The detent uses the fast flag from before this item's tick.
        if (r_sel) begin
            step = r_fast ? i_cfg.fast_i : i_cfg.slow_i;
        end else begin
            step = r_fast ? i_cfg.fast_v : i_cfg.slow_v;
        end
        moved = sat_move(r_sel ? r_curr : r_volt, step, det == DET_CW);

        if (det != DET_NONE) begin
            if (r_sel) begin
                n_curr = moved;
            end else begin
                n_volt = moved;
            end
            n_hist = HIST_IDLE;
            if (r_rot != CNT_MAX) begin
                n_rot = r_rot + 1'b1;
            end
        end

        // Switch clicks; both pressed together is ignored.
        case (i_item.sw)
            SW_OUTPUT: begin
                n_out_on = !r_out_on;
                beep     = 1'b1;
            end
            SW_ENCODER: begin
                n_sel = !r_sel;
                beep  = 1'b1;
            end
            default: begin
            end
        endcase

        // Rate interval end: decide the step size from the last two counts.
        rate_sum = {1'b0, r_prev} + {1'b0, n_rot};
        if (i_item.tick) begin
            n_fast = (rate_sum > i_cfg.thresh);
            n_prev = n_rot;
            n_rot  = '0;
        end
    end

    // State registers advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= HIST_IDLE;
            r_rot    <= '0;
            r_prev   <= '0;
            r_fast   <= 1'b0;
            r_sel    <= 1'b0;
            r_out_on <= 1'b1;
            r_volt   <= '0;
            r_curr   <= '0;
        end else if (i_advance) begin
            r_hist   <= n_hist;
            r_rot    <= n_rot;
            r_prev   <= n_prev;
            r_fast   <= n_fast;
            r_sel    <= n_sel;
            r_out_on <= n_out_on;
            r_volt   <= n_volt;
            r_curr   <= n_curr;
        end
    end

    // Result fields taken from the state after this item.
    always_comb begin
        o_result.voltage     = to_out(n_volt);
        o_result.current     = to_out(n_curr);
        o_result.output_on   = n_out_on;
        o_result.adj_current = n_sel;
        o_result.fast_mode   = n_fast;
        o_result.detent      = det;
        o_result.dac_v       = {DAC_V_CMD, top12(n_volt)};
        o_result.dac_i       = {DAC_I_CMD, top12(n_curr)};
        o_result.dac_update  = (det != DET_NONE);
        o_result.beep        = beep;
    end

endmodule
